// ----- rtl/core/erp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types and codes for the event ring producer.
// ----------------------------------------------------------------------------
package erp_pkg;

    // Operation codes
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_TRY_ADD  = 2'd1;
    localparam logic [1:0] OP_SET_RGET = 2'd2;
    localparam logic [1:0] OP_SET_DGET = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DISABLED = 3'd1;
    localparam logic [2:0] ST_NO_ROOM  = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_KEEP_NEWEST = 3'd1;
    localparam logic [2:0] CFG_MAINTAIN    = 3'd2;
    localparam logic [2:0] CFG_RING_RECS   = 3'd3;
    localparam logic [2:0] CFG_DATA_BYTES  = 3'd4;
    localparam logic [2:0] CFG_REC_THR     = 3'd5;
    localparam logic [2:0] CFG_DATA_THR    = 3'd6;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classified request handed from front to back
    typedef struct packed {
        logic        is_add;
        logic        is_try;
        logic        is_rget;
        logic        is_dget;
        logic        use_rem;
        logic [15:0] kind;
        logic [15:0] subkind;
        logic [16:0] nbytes;
        logic [16:0] get_pos;
    } item_t;

endpackage

// ----- rtl/core/event_ring_producer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_ring_producer
// Producer-side pointer and space manager for a record ring and a data ring.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. A two-entry queue takes requests in
// while the back end works; the back end handles one request at a time. Add,
// try-add and set-data-get leave the queue, execute, and load the output
// register; the load waits while the output register holds a stalled result.
// A set-record-get first passes through the bit-serial remainder unit (17
// steps), which reduces the record get position modulo the ring size.
// Data lengths are rounded up to the granule by a constant reciprocal multiply
// as the request leaves the queue. A finished result waits in an output
// register while the next request is already being worked on. Configuration
// writes are always ready.
module event_ring_producer #(
    parameter int MAX_RECORDS    = 4096,
    parameter int MAX_DATA_BYTES = 65536,
    parameter int GRANULE_BYTES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] event_kind,
    input  logic [15:0] event_subkind,
    input  logic [16:0] data_bytes,
    input  logic [16:0] new_get,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        record_written,
    output logic [11:0] record_slot,
    output logic [15:0] header_kind,
    output logic [15:0] header_subkind,
    output logic [16:0] data_end_offset,
    output logic        data_wrapped,
    output logic [15:0] data_write_start,
    output logic        data_dropped,
    output logic        notify,
    output logic [31:0] record_drops,
    output logic [31:0] data_drops
);
    import erp_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_pop;

    assign cfg_ready = 1'b1;

    erp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .event_kind    (event_kind),
        .event_subkind (event_subkind),
        .data_bytes    (data_bytes),
        .new_get       (new_get),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    erp_back #(
        .MAX_RECORDS    (MAX_RECORDS),
        .MAX_DATA_BYTES (MAX_DATA_BYTES),
        .GRANULE_BYTES  (GRANULE_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item             (item),
        .item_pop         (item_pop),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .record_written   (record_written),
        .record_slot      (record_slot),
        .header_kind      (header_kind),
        .header_subkind   (header_subkind),
        .data_end_offset  (data_end_offset),
        .data_wrapped     (data_wrapped),
        .data_write_start (data_write_start),
        .data_dropped     (data_dropped),
        .notify           (notify),
        .record_drops     (record_drops),
        .data_drops       (data_drops)
    );

endmodule

// ----- rtl/core/erp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_front
// Accepts requests, decodes the operation and queues them for the back end.
// ----------------------------------------------------------------------------
module erp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      operation,
    input  logic [15:0]     event_kind,
    input  logic [15:0]     event_subkind,
    input  logic [16:0]     data_bytes,
    input  logic [16:0]     new_get,
    output logic            item_valid,
    output erp_pkg::item_t  item,
    input  logic            item_pop
);
    import erp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t             queue_mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;
    item_t             decoded;
    logic              push;
    logic              pop;

    // Decode the operation
    always_comb
    begin
        decoded         = '0;
        decoded.kind    = event_kind;
        decoded.subkind = event_subkind;
        decoded.nbytes  = data_bytes;
        decoded.get_pos = new_get;
        case (operation)
            OP_ADD:      decoded.is_add  = 1'b1;
            OP_TRY_ADD:  decoded.is_try  = 1'b1;
            OP_SET_RGET: decoded.is_rget = 1'b1;
            OP_SET_DGET: decoded.is_dget = 1'b1;
            default:     decoded.is_dget = 1'b1;
        endcase
        // only the record get position needs the remainder unit
        decoded.use_rem = decoded.is_rget;
    end

    assign in_stall   = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign push       = in_valid & ~in_stall;
    assign pop        = item_pop & item_valid;
    assign item_valid = (count_reg != '0);
    assign item       = queue_mem[rd_ptr_reg];

    // Advance pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ----- rtl/core/erp_rem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module erp_rem #(
    parameter int QW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [16:0]   dividend,
    input  logic [QW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] result
);
    localparam int NB = 17;
    localparam int CW = $clog2(NB + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [16:0]   dvd_reg, dvd_next;
    logic [QW-1:0] dsr_reg, dsr_next;
    logic [QW-1:0] part_reg, part_next;
    logic [QW:0]   trial;

    assign trial  = {part_reg, dvd_reg[16]};
    assign result = part_reg;
    assign done   = (cnt_reg == CW'(1));

    // Shift in one bit and subtract when it fits
    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        part_next = part_reg;
        if (start)
        begin
            cnt_next  = CW'(NB);
            dvd_next  = dividend;
            dsr_next  = divisor;
            part_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[15:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                part_next = QW'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                part_next = trial[QW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        part_reg <= part_next;
    end

endmodule

// ----- rtl/core/erp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_back
// Executes queued requests against the ring pointers and drives results.
// ----------------------------------------------------------------------------
module erp_back #(
    parameter int MAX_RECORDS    = 4096,
    parameter int MAX_DATA_BYTES = 65536,
    parameter int GRANULE_BYTES  = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  erp_pkg::item_t  item,
    output logic            item_pop,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [16:0]     cfg_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      status,
    output logic            record_written,
    output logic [11:0]     record_slot,
    output logic [15:0]     header_kind,
    output logic [15:0]     header_subkind,
    output logic [16:0]     data_end_offset,
    output logic            data_wrapped,
    output logic [15:0]     data_write_start,
    output logic            data_dropped,
    output logic            notify,
    output logic [31:0]     record_drops,
    output logic [31:0]     data_drops
);
    import erp_pkg::*;

    localparam int RPW = $clog2(MAX_RECORDS);
    localparam int RCW = $clog2(MAX_RECORDS + 1);
    localparam int RXW = (RCW > 13) ? RCW : 13;
    localparam int DPW = $clog2(MAX_DATA_BYTES + 1);
    localparam int DCW = $clog2(MAX_DATA_BYTES + 262144);
    localparam int QW  = (RCW > 7) ? RCW : 7;

    // Reciprocal of the granule, exact for 18-bit dividends
    localparam int GL = $clog2(GRANULE_BYTES);
    localparam int RS = 18 + GL;
    localparam logic [19:0] RECIP =
        20'(((64'd1 << RS) + 64'(GRANULE_BYTES) - 64'd1) / 64'(GRANULE_BYTES));

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]     state_reg, state_next;
    item_t          cur_reg;
    logic [DCW-1:0] al_reg;

    // Configuration
    logic           en_reg, kn_reg, mc_reg;
    logic [12:0]    rrec_reg;
    logic [16:0]    dsz_reg;
    logic [12:0]    rthr_reg;
    logic [16:0]    dthr_reg;

    // Ring state
    logic [RPW-1:0] rput_reg, rget_reg;
    logic [RCW-1:0] rfill_reg;
    logic [31:0]    rdrop_reg, ddrop_reg;
    logic [DPW-1:0] dput_reg;
    logic [16:0]    dget_reg;
    logic [DCW-1:0] drem_reg;

    // Staged result
    logic [2:0]     res_status_reg;
    logic           res_written_reg;
    logic [11:0]    res_slot_reg;
    logic [15:0]    res_kind_reg, res_sub_reg;
    logic [16:0]    res_end_reg;
    logic           res_wrap_reg;
    logic [15:0]    res_start_reg;
    logic           res_drop_reg;

    // Output register
    logic           out_valid_reg;
    logic [2:0]     out_status_reg;
    logic           out_written_reg;
    logic [11:0]    out_slot_reg;
    logic [15:0]    out_kind_reg, out_sub_reg;
    logic [16:0]    out_end_reg;
    logic           out_wrap_reg;
    logic [15:0]    out_start_reg;
    logic           out_drop_reg;
    logic           out_notify_reg;
    logic [31:0]    out_rdrop_reg, out_ddrop_reg;

    logic           rem_start;
    logic           rem_done;
    logic [QW-1:0]  rem_divisor;
    logic [16:0]    rem_dividend;
    logic [QW-1:0]  rem_result;

    logic [17:0]    gran_sum;
    logic [43:0]    gran_prod;
    logic [17:0]    gran_quot;
    logic [DCW-1:0] al_calc;

    logic [RXW-1:0] rrec_x, tot_x;
    logic [RCW-1:0] tot;
    logic [DCW-1:0] dsz_x, size;
    logic [DCW-1:0] cfg_size;
    logic [RCW-1:0] put_inc;
    logic [RPW-1:0] put_ring_next;
    logic           ring_full;
    logic [DCW-1:0] al, put_x, get_x, eg, end_x, start_x, put_end;
    logic           fit_lin, rem_ok, fits, place_drop, do_write, rec_drop;
    logic [RPW-1:0] new_rget;
    logic [2:0]     exec_status;
    logic           out_load;
    logic [RCW-1:0] used, free_cnt, fill_free;
    logic           rec_note;
    logic [RPW+11:0] slot_w;
    logic [DCW+16:0] end_w, start_w;

    function automatic logic [RCW-1:0] fill_of(input logic [RPW-1:0] p,
                                               input logic [RPW-1:0] g,
                                               input logic [RCW-1:0] t);
        logic [RCW-1:0] px;
        logic [RCW-1:0] gx;
        px = RCW'(p);
        gx = RCW'(g);
        if (gx <= px)
        begin
            return px - gx;
        end
        return px + (t - gx);
    endfunction

    function automatic logic [DCW-1:0] room_of(input logic [DCW-1:0] g,
                                               input logic [DCW-1:0] p,
                                               input logic [DCW-1:0] s);
        if (g <= p)
        begin
            return g + (s - p);
        end
        return g - p;
    endfunction

    // Clamp ring sizes
    assign rrec_x = RXW'(rrec_reg);
    assign tot_x  = (rrec_x == '0) ? RXW'(1) :
                    (rrec_x > RXW'(MAX_RECORDS)) ? RXW'(MAX_RECORDS) : rrec_x;
    assign tot    = tot_x[RCW-1:0];
    assign dsz_x  = DCW'(dsz_reg);
    assign size   = (dsz_x > DCW'(MAX_DATA_BYTES)) ? DCW'(MAX_DATA_BYTES) : dsz_x;
    assign cfg_size = (DCW'(cfg_data) > DCW'(MAX_DATA_BYTES)) ?
                      DCW'(MAX_DATA_BYTES) : DCW'(cfg_data);

    // Round the data length up to the granule
    assign gran_sum  = 18'(item.nbytes) + 18'(GRANULE_BYTES - 1);
    assign gran_prod = 44'(gran_sum) * 44'(RECIP);
    assign gran_quot = gran_prod[RS +: 18];
    assign al_calc   = DCW'(gran_quot) * DCW'(GRANULE_BYTES);

    // Record ring room
    assign put_inc       = RCW'(rput_reg) + 1'b1;
    assign put_ring_next = (put_inc == tot) ? '0 : put_inc[RPW-1:0];
    assign ring_full     = (put_ring_next == rget_reg);
    assign new_rget      = rem_result[RPW-1:0];

    // Data ring placement
    assign al      = al_reg;
    assign put_x   = DCW'(dput_reg);
    assign get_x   = DCW'(dget_reg);
    assign put_end = put_x + al;
    assign fit_lin = (put_end <= size);
    assign eg      = (get_x >= size) ? '0 : get_x;
    assign rem_ok  = (drem_reg >= al);
    assign fits    = (cur_reg.nbytes == '0) ||
                     (fit_lin ? rem_ok : ((al <= size) && (eg > al)));
    assign place_drop = fit_lin ? (!kn_reg && !rem_ok) :
                        ((al > size) || (!kn_reg && (eg <= al)));
    assign start_x = fit_lin ? put_x : '0;
    assign end_x   = fit_lin ? put_end : al;

    // Classify the outcome
    always_comb
    begin
        do_write    = 1'b0;
        rec_drop    = 1'b0;
        exec_status = ST_OK;
        if (cur_reg.is_add)
        begin
            if (!en_reg)
            begin
                exec_status = ST_DISABLED;
            end
            else if (!kn_reg && ring_full)
            begin
                rec_drop    = 1'b1;
                exec_status = ST_DROPPED;
            end
            else
            begin
                do_write = 1'b1;
            end
        end
        else if (cur_reg.is_try)
        begin
            if (kn_reg)
            begin
                exec_status = ST_INVALID;
            end
            else if (!en_reg)
            begin
                exec_status = ST_DISABLED;
            end
            else if (ring_full || !fits)
            begin
                exec_status = ST_NO_ROOM;
            end
            else
            begin
                do_write = 1'b1;
            end
        end
    end

    assign slot_w  = (RPW+12)'(rput_reg);
    assign end_w   = (DCW+17)'(end_x);
    assign start_w = (DCW+17)'(start_x);

    // Notify from the settled state
    assign used      = fill_of(rput_reg, rget_reg, tot);
    assign free_cnt  = tot - 1'b1 - used;
    assign fill_free = (rfill_reg > tot) ? '0 : tot - rfill_reg;
    assign rec_note  = mc_reg ? (RXW'(free_cnt) <= RXW'(rthr_reg)) :
                                (RXW'(fill_free) <= RXW'(rthr_reg));

    // Sequence one request
    assign item_pop     = (state_reg == S_IDLE) && item_valid;
    assign rem_start    = item_pop && item.use_rem;
    assign rem_dividend = item.get_pos;
    assign rem_divisor  = QW'(tot);
    assign out_load     = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item.use_rem ? S_DIV : S_EXEC;
                end
            end
            S_DIV:
            begin
                if (rem_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    erp_rem #(
        .QW (QW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .done     (rem_done),
        .result   (rem_result)
    );

    // Hold the request under work
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            cur_reg <= item;
            al_reg  <= al_calc;
        end
    end

    // Configuration and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            en_reg    <= 1'b0;
            kn_reg    <= 1'b0;
            mc_reg    <= 1'b0;
            rrec_reg  <= 13'd4096;
            dsz_reg   <= 17'd65536;
            rthr_reg  <= '0;
            dthr_reg  <= '0;
            rput_reg  <= '0;
            rget_reg  <= '0;
            rfill_reg <= '0;
            rdrop_reg <= '0;
            ddrop_reg <= '0;
            dput_reg  <= '0;
            dget_reg  <= '0;
            drem_reg  <= (DCW'(65536) > DCW'(MAX_DATA_BYTES)) ?
                         DCW'(MAX_DATA_BYTES) : DCW'(65536);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:      en_reg <= cfg_data[0];
                    CFG_KEEP_NEWEST: kn_reg <= cfg_data[0];
                    CFG_MAINTAIN:    mc_reg <= cfg_data[0];
                    CFG_RING_RECS:
                    begin
                        rrec_reg  <= cfg_data[12:0];
                        rput_reg  <= '0;
                        rget_reg  <= '0;
                        rfill_reg <= '0;
                    end
                    CFG_DATA_BYTES:
                    begin
                        dsz_reg  <= cfg_data;
                        dput_reg <= '0;
                        dget_reg <= '0;
                        drem_reg <= cfg_size;
                    end
                    CFG_REC_THR:     rthr_reg <= cfg_data[12:0];
                    CFG_DATA_THR:    dthr_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            else if (state_reg == S_EXEC)
            begin
                if (rec_drop)
                begin
                    rdrop_reg <= rdrop_reg + 1'b1;
                end
                if (do_write)
                begin
                    rput_reg <= put_ring_next;
                    if (place_drop)
                    begin
                        ddrop_reg <= ddrop_reg + 1'b1;
                    end
                    else
                    begin
                        dput_reg <= end_x[DPW-1:0];
                        if (!kn_reg)
                        begin
                            drem_reg <= room_of(get_x, end_x, size);
                        end
                    end
                    if (cur_reg.is_try && mc_reg)
                    begin
                        rfill_reg <= fill_of(put_ring_next, rget_reg, tot);
                    end
                end
                if (cur_reg.is_rget)
                begin
                    rget_reg  <= new_rget;
                    rfill_reg <= fill_of(rput_reg, new_rget, tot);
                    rdrop_reg <= '0;
                    ddrop_reg <= '0;
                end
                if (cur_reg.is_dget)
                begin
                    dget_reg <= cur_reg.get_pos;
                    if (!kn_reg)
                    begin
                        drem_reg <= room_of(DCW'(cur_reg.get_pos), put_x, size);
                    end
                end
            end
        end
    end

    // Stage result fields
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            res_status_reg  <= exec_status;
            res_written_reg <= do_write;
            res_slot_reg    <= do_write ? slot_w[11:0] : '0;
            res_kind_reg    <= do_write ? cur_reg.kind : '0;
            res_sub_reg     <= do_write ? cur_reg.subkind : '0;
            res_end_reg     <= !do_write ? '0 :
                               place_drop ? 17'(put_x) : end_w[16:0];
            res_wrap_reg    <= do_write && !place_drop && !fit_lin;
            res_start_reg   <= (do_write && !place_drop) ? start_w[15:0] : '0;
            res_drop_reg    <= do_write && place_drop;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_written_reg <= res_written_reg;
            out_slot_reg    <= res_slot_reg;
            out_kind_reg    <= res_kind_reg;
            out_sub_reg     <= res_sub_reg;
            out_end_reg     <= res_end_reg;
            out_wrap_reg    <= res_wrap_reg;
            out_start_reg   <= res_start_reg;
            out_drop_reg    <= res_drop_reg;
            out_notify_reg  <= rec_note || (drem_reg <= DCW'(dthr_reg));
            out_rdrop_reg   <= rdrop_reg;
            out_ddrop_reg   <= ddrop_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign record_written   = out_written_reg;
    assign record_slot      = out_slot_reg;
    assign header_kind      = out_kind_reg;
    assign header_subkind   = out_sub_reg;
    assign data_end_offset  = out_end_reg;
    assign data_wrapped     = out_wrap_reg;
    assign data_write_start = out_start_reg;
    assign data_dropped     = out_drop_reg;
    assign notify           = out_notify_reg;
    assign record_drops     = out_rdrop_reg;
    assign data_drops       = out_ddrop_reg;

endmodule

// ----- rtl/core/erp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_checker
// Port-level checks on the event ring producer, bound to the top level.
// ----------------------------------------------------------------------------
module erp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        record_written,
    input logic [16:0] data_end_offset,
    input logic        data_wrapped,
    input logic [15:0] data_write_start,
    input logic        data_dropped
);
    import erp_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // Only a successful request fills a record slot
    a_status_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !record_written)
        else $error("record written with failing status");

    // Dropped data carries no placement
    a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_dropped |-> !data_wrapped && data_write_start == '0)
        else $error("dropped data reports a placement");

    // No record means no data fields
    a_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !record_written |->
            data_end_offset == '0 && !data_dropped && !data_wrapped)
        else $error("data fields set without a record");

endmodule

bind event_ring_producer erp_checker u_erp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .record_written   (record_written),
    .data_end_offset  (data_end_offset),
    .data_wrapped     (data_wrapped),
    .data_write_start (data_write_start),
    .data_dropped     (data_dropped)
);
